// ----- src/gsg_pkg.sv -----
// Package for the grid stencil generation step: configuration register codes,
// rule constants, queue depth and the per-word flag group.
// Depends on nothing; used by gsg_front, gsg_back and the top level.
package gsg_pkg;

	localparam int IN_BITS        = 8;
	localparam int OUT_BITS       = 8;
	localparam int WIDTH_CFG_BITS = 13;
	localparam int HEIGHT_BITS    = 16;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 1;

	localparam int MIN_DIM   = 3;
	localparam int RESET_DIM = 4096;

	localparam int RULE_LOW  = 50;
	localparam int RULE_HIGH = 150;
	localparam int RULE_STEP = 3;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic emit;
		logic interior;
		logic last;
	} item_flags_t;

endpackage

// ----- src/gsg_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module gsg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- src/gsg_fifo.sv -----
// Small register FIFO with an occupancy count, used between front and back
// and on the result side. Depends on nothing.
module gsg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH+1);

	logic [WIDTH-1:0]    buf_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = buf_q[rd_ptr_q];
	assign do_push = push && (count_q != CNT_BITS'(DEPTH));
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/gsg_front.sv -----
// Front end: accepts cell words, keeps row/column position and grid size,
// and reads/updates the line store that holds both previous rows. Depends on gsg_pkg and gsg_ram.
module gsg_front #(
	parameter int MAX_COLS  = 4096,
	parameter int CELL_BITS = 8
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        push,
	output logic                                        full,
	input  logic [gsg_pkg::IN_BITS-1:0]                 cell_value,
	input  logic                                        cfg_write,
	input  logic [gsg_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
	input  logic [gsg_pkg::CFG_DATA_BITS-1:0]           cfg_data,
	output logic                                        q_push,
	output logic [3*CELL_BITS-1:0]                      q_data,
	output gsg_pkg::item_flags_t                        q_flags,
	input  logic [$clog2(gsg_pkg::QUEUE_DEPTH+1)-1:0]   q_count
);

	localparam int COL_BITS  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int WBITS     = (COL_BITS + 1 > gsg_pkg::WIDTH_CFG_BITS) ?
	                           COL_BITS + 1 : gsg_pkg::WIDTH_CFG_BITS;
	localparam int HBITS     = gsg_pkg::HEIGHT_BITS;
	localparam int QCNT_BITS = $clog2(gsg_pkg::QUEUE_DEPTH+1);
	localparam int RESET_W   = (gsg_pkg::RESET_DIM < MAX_COLS) ? gsg_pkg::RESET_DIM : MAX_COLS;

	logic [WBITS-1:0]     wm1_q;
	logic [HBITS-1:0]     hm1_q;
	logic [WBITS-1:0]     wm1_next;
	logic [HBITS-1:0]     hm1_next;
	logic [WBITS-1:0]     cfg_w;
	logic [HBITS-1:0]     cfg_h;

	logic [COL_BITS-1:0]  col_q;
	logic [HBITS-1:0]     row_q;
	logic [WBITS-1:0]     col_ext;
	logic                 accept;
	logic                 last_col;
	logic                 last_row;
	gsg_pkg::item_flags_t flags;

	logic                 valid_s1;
	logic [CELL_BITS-1:0] cell_s1;
	logic [COL_BITS-1:0]  col_s1;
	gsg_pkg::item_flags_t flags_s1;

	logic [2*CELL_BITS-1:0] rd_data;
	logic [CELL_BITS-1:0]   top;
	logic [CELL_BITS-1:0]   mid;
	logic [QCNT_BITS:0]     in_flight;

	assign cfg_w = WBITS'(cfg_data[gsg_pkg::WIDTH_CFG_BITS-1:0]);
	assign cfg_h = cfg_data[HBITS-1:0];

	always_comb begin
		if (cfg_w < WBITS'(gsg_pkg::MIN_DIM)) begin
			wm1_next = WBITS'(gsg_pkg::MIN_DIM - 1);
		end else if (cfg_w > WBITS'(MAX_COLS)) begin
			wm1_next = WBITS'(MAX_COLS - 1);
		end else begin
			wm1_next = cfg_w - 1'b1;
		end
		if (cfg_h < HBITS'(gsg_pkg::MIN_DIM)) begin
			hm1_next = HBITS'(gsg_pkg::MIN_DIM - 1);
		end else begin
			hm1_next = cfg_h - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= WBITS'(RESET_W - 1);
			hm1_q <= HBITS'(gsg_pkg::RESET_DIM - 1);
		end else if (cfg_write) begin
			unique case (gsg_pkg::cfg_reg_t'(cfg_index))
				gsg_pkg::REG_GRID_WIDTH:  wm1_q <= wm1_next;
				gsg_pkg::REG_GRID_HEIGHT: hm1_q <= hm1_next;
			endcase
		end
	end

	assign in_flight = (QCNT_BITS+1)'(q_count) + (QCNT_BITS+1)'(valid_s1);
	assign full      = (in_flight >= (QCNT_BITS+1)'(gsg_pkg::QUEUE_DEPTH));
	assign accept    = push && !full;

	assign col_ext  = WBITS'(col_q);
	assign last_col = (col_ext >= wm1_q);
	assign last_row = (row_q >= hm1_q);

	always_comb begin
		flags.emit     = (row_q != '0) && (col_q != '0);
		flags.interior = (row_q >= HBITS'(2)) && (col_q >= COL_BITS'(2)) &&
		                 (row_q <= hm1_q) && (col_ext <= wm1_q);
		flags.last     = last_row && last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1  <= CELL_BITS'(cell_value);
			col_s1   <= col_q;
			flags_s1 <= flags;
		end
	end

	gsg_ram #(
		.WIDTH (2*CELL_BITS),
		.DEPTH (MAX_COLS)
	) u_line_store (
		.clk     (clk),
		.wr_en   (valid_s1),
		.wr_addr (col_s1),
		.wr_data ({mid, cell_s1}),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data)
	);

	assign top = rd_data[2*CELL_BITS-1:CELL_BITS];
	assign mid = rd_data[CELL_BITS-1:0];

	assign q_push  = valid_s1;
	assign q_data  = {top, mid, cell_s1};
	assign q_flags = flags_s1;

endmodule

// ----- src/gsg_back.sv -----
// Back end: slides the 3x3 window, sums the neighbourhood and applies the
// generation rule. Depends on gsg_pkg.
module gsg_back #(
	parameter int CELL_BITS = 8
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic [3*CELL_BITS-1:0]                      q_data,
	input  gsg_pkg::item_flags_t                        q_flags,
	input  logic                                        q_empty,
	output logic                                        q_pop,
	output logic                                        out_push,
	output logic [gsg_pkg::OUT_BITS:0]                  out_data,
	input  logic [$clog2(gsg_pkg::QUEUE_DEPTH+1)-1:0]   out_count
);

	localparam int SUM_BITS  = CELL_BITS + 4;
	localparam int NNIB      = (SUM_BITS + 3) / 4;
	localparam int PAD_BITS  = NNIB * 4;
	localparam int OCNT_BITS = $clog2(gsg_pkg::QUEUE_DEPTH+1);

	logic [CELL_BITS-1:0] win_q [3][3];
	logic                 valid_s2;
	gsg_pkg::item_flags_t flags_s2;
	logic                 valid_s3;
	logic [SUM_BITS-1:0]  sum_s3;
	logic [CELL_BITS-1:0] centre_s3;
	logic                 interior_s3;
	logic                 last_s3;

	logic [OCNT_BITS+1:0] pending;
	logic [SUM_BITS-1:0]  sum;
	logic [PAD_BITS-1:0]  sum_pad;
	logic [7:0]           nib_sum;
	logic [4:0]           fold1;
	logic [4:0]           fold2;
	logic                 mult10;
	logic [CELL_BITS:0]   centre_up;
	logic [CELL_BITS-1:0] plus_v;
	logic [CELL_BITS-1:0] minus_v;
	logic [CELL_BITS-1:0] rule_v;

	assign pending = (OCNT_BITS+2)'(out_count) + (OCNT_BITS+2)'(valid_s2) +
	                 (OCNT_BITS+2)'(valid_s3);
	assign q_pop   = !q_empty && (pending < (OCNT_BITS+2)'(gsg_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= q_pop && q_flags.emit;
			valid_s3 <= valid_s2;
			if (q_pop) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2] <= q_data[3*CELL_BITS-1:2*CELL_BITS];
				win_q[1][2] <= q_data[2*CELL_BITS-1:CELL_BITS];
				win_q[2][2] <= q_data[CELL_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			flags_s2 <= q_flags;
		end
		if (valid_s2) begin
			sum_s3      <= sum;
			centre_s3   <= win_q[1][1];
			interior_s3 <= flags_s2.interior;
			last_s3     <= flags_s2.last;
		end
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				sum = sum + SUM_BITS'(win_q[i][j]);
			end
		end
	end

	// multiple of ten: even, and hex digits fold to a multiple of five
	always_comb begin
		sum_pad = PAD_BITS'(sum_s3);
		nib_sum = '0;
		for (int k = 0; k < NNIB; k++) begin
			nib_sum = nib_sum + 8'(sum_pad[4*k +: 4]);
		end
		fold1  = 5'(nib_sum[7:4]) + 5'(nib_sum[3:0]);
		fold2  = 5'(fold1[4]) + 5'(fold1[3:0]);
		mult10 = !sum_s3[0] && ((fold2 == 5'd0) || (fold2 == 5'd5) ||
		                        (fold2 == 5'd10) || (fold2 == 5'd15));
	end

	assign centre_up = (CELL_BITS+1)'(centre_s3) + (CELL_BITS+1)'(gsg_pkg::RULE_STEP);
	assign plus_v    = centre_up[CELL_BITS] ? '1 : centre_up[CELL_BITS-1:0];
	assign minus_v   = (centre_s3 > CELL_BITS'(gsg_pkg::RULE_STEP)) ?
	                   centre_s3 - CELL_BITS'(gsg_pkg::RULE_STEP) : '0;

	always_comb begin
		if (!interior_s3 || mult10) begin
			rule_v = '0;
		end else if (sum_s3 < SUM_BITS'(gsg_pkg::RULE_LOW)) begin
			rule_v = plus_v;
		end else if ((sum_s3 > SUM_BITS'(gsg_pkg::RULE_LOW)) &&
		             (sum_s3 < SUM_BITS'(gsg_pkg::RULE_HIGH))) begin
			rule_v = minus_v;
		end else begin
			rule_v = CELL_BITS'(1);
		end
	end

	assign out_push = valid_s3;
	assign out_data = {gsg_pkg::OUT_BITS'(rule_v), last_s3};

endmodule

// ----- src/grid_stencil_generation_step.sv -----
// Top level of the grid stencil generation step: front end, word queue,
// back end and result queue. Depends on gsg_pkg, gsg_front, gsg_fifo, gsg_back.
//
// Takes one cell word per cycle, while full is low, in raster order and, from the
// second row and column on, returns one word per accepted cell: the next value of
// the cell one row up and one column left, with frame_last on the last word of a
// grid. A word passes from push to the result queue through the line store read,
// the word queue, the window and the neighbourhood sum, with the rule applied on
// entry to the result queue. Sustained rate is one word per cycle while results are
// popped and full stays low, set by the line store, a RAM of MAX_COLS entries
// holding both previous rows that is read and written once per word. The line store
// needs no clearing after reset. Write grid_width and grid_height only between grids.
module grid_stencil_generation_step #(
	parameter int MAX_COLS  = 4096,
	parameter int CELL_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [gsg_pkg::IN_BITS-1:0]        cell_value,
	output logic                               empty,
	input  logic                               pop,
	output logic [gsg_pkg::OUT_BITS-1:0]       next_value,
	output logic                               frame_last,
	input  logic                               cfg_write,
	input  logic [gsg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [gsg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int QCNT_BITS = $clog2(gsg_pkg::QUEUE_DEPTH+1);
	localparam int FLAG_BITS = $bits(gsg_pkg::item_flags_t);
	localparam int MID_BITS  = 3*CELL_BITS + FLAG_BITS;
	localparam int RES_BITS  = gsg_pkg::OUT_BITS + 1;

	logic                   fq_push;
	logic [3*CELL_BITS-1:0] fq_data;
	gsg_pkg::item_flags_t   fq_flags;
	logic [MID_BITS-1:0]    mq_rdata;
	logic                   mq_empty;
	logic                   mq_pop;
	logic [QCNT_BITS-1:0]   mq_count;
	gsg_pkg::item_flags_t   mq_flags;

	logic                   res_push;
	logic [RES_BITS-1:0]    res_wdata;
	logic [RES_BITS-1:0]    res_rdata;
	logic [QCNT_BITS-1:0]   res_count;

	gsg_front #(
		.MAX_COLS  (MAX_COLS),
		.CELL_BITS (CELL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cell_value (cell_value),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_push     (fq_push),
		.q_data     (fq_data),
		.q_flags    (fq_flags),
		.q_count    (mq_count)
	);

	gsg_fifo #(
		.WIDTH (MID_BITS),
		.DEPTH (gsg_pkg::QUEUE_DEPTH)
	) u_word_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wdata  ({fq_data, fq_flags}),
		.pop    (mq_pop),
		.rdata  (mq_rdata),
		.empty  (mq_empty),
		.count  (mq_count)
	);

	assign mq_flags = gsg_pkg::item_flags_t'(mq_rdata[FLAG_BITS-1:0]);

	gsg_back #(
		.CELL_BITS (CELL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (mq_rdata[MID_BITS-1:FLAG_BITS]),
		.q_flags   (mq_flags),
		.q_empty   (mq_empty),
		.q_pop     (mq_pop),
		.out_push  (res_push),
		.out_data  (res_wdata),
		.out_count (res_count)
	);

	gsg_fifo #(
		.WIDTH (RES_BITS),
		.DEPTH (gsg_pkg::QUEUE_DEPTH)
	) u_result_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty),
		.count  (res_count)
	);

	assign next_value = res_rdata[RES_BITS-1:1];
	assign frame_last = res_rdata[0];

endmodule

// ----- bench/testbench.sv -----
// Testbench for grid_stencil_generation_step: streams raster grids of cell words through
// the queue ports and checks every next-generation word against an in-bench predictor.
// Depends on gsg_pkg and the block's RTL under src.
module testbench;

	localparam int MAX_COLS      = 4096;
	localparam int CELL_BITS     = 8;
	localparam int CELL_MAX      = (1 << CELL_BITS) - 1;
	localparam int RULE_MODULUS  = 10;
	localparam int PHASE_ITEMS   = 360;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_STALL    = 300;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int ROW_BITS      = gsg_pkg::HEIGHT_BITS;
	localparam int COL_CFG_BITS  = gsg_pkg::WIDTH_CFG_BITS;
	localparam int CFG_BITS      = gsg_pkg::CFG_DATA_BITS;

	localparam logic [7:0] DIRECTED_CELLS [21] = '{
		8'd4, 8'd6,  8'd9, 8'd2, 8'd60, 8'd10, 8'd255,
		8'd3, 8'd10, 8'd2, 8'd8, 8'd50, 8'd1,  8'd255,
		8'd3, 8'd4,  8'd8, 8'd2, 8'd8,  8'd10, 8'd255
	};

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		logic [gsg_pkg::OUT_BITS-1:0] next_value;
		logic                         frame_last;
	} gen_word_t;

	logic                               clk;
	logic                               arst_n;
	logic                               push;
	logic                               full;
	logic [gsg_pkg::IN_BITS-1:0]        cell_value;
	logic                               empty;
	logic                               pop;
	logic [gsg_pkg::OUT_BITS-1:0]       next_value;
	logic                               frame_last;
	logic                               cfg_write;
	logic [gsg_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]                cfg_data;

	logic [7:0]                cell_backlog [$];
	gen_word_t                 next_gen_words [$];

	logic [7:0]                prev_row [MAX_COLS];
	logic [7:0]                older_row [MAX_COLS];
	logic [7:0]                window [3][3];
	logic [ROW_BITS-1:0]       row_at;
	logic [COL_CFG_BITS-1:0]   col_at;
	logic [COL_CFG_BITS-1:0]   width_reg;
	logic [ROW_BITS-1:0]       height_reg;

	int                        send_idle_pct;
	int                        recv_idle_pct;
	int                        stall_request;
	int                        stall_left;
	bit                        offer_held;
	int                        mismatches;
	int                        cycles;

	grid_stencil_generation_step #(
		.MAX_COLS  (MAX_COLS),
		.CELL_BITS (CELL_BITS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cell_value (cell_value),
		.empty      (empty),
		.pop        (pop),
		.next_value (next_value),
		.frame_last (frame_last),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	function automatic int eff_width();
		if (width_reg < gsg_pkg::MIN_DIM)
			return gsg_pkg::MIN_DIM;
		if (width_reg > MAX_COLS)
			return MAX_COLS;
		return width_reg;
	endfunction

	function automatic int eff_height();
		return (height_reg < gsg_pkg::MIN_DIM) ? gsg_pkg::MIN_DIM : height_reg;
	endfunction

	function automatic logic [7:0] rand_cell(input int scale);
		case ($urandom_range(0, 15))
			0: return '0;
			1: return CELL_MAX;
			2, 3: return 8'($urandom_range(0, CELL_MAX));
			default: return 8'($urandom_range(0, scale));
		endcase
	endfunction

	// Shift one cell into the line stores and window; queue the word it produces.
	task automatic advance_grid(input logic [7:0] cell_in);
		int w, h, r, c, sum, centre, v, i, j;
		logic [7:0] top, mid;
		bit last_col, last_row;
		gen_word_t word;
		w = eff_width();
		h = eff_height();
		r = row_at;
		c = col_at;
		top = '0;
		mid = '0;
		last_col = c >= w - 1;
		last_row = r >= h - 1;
		if (c < MAX_COLS) begin
			top = older_row[c];
			mid = prev_row[c];
			older_row[c] = mid;
			prev_row[c] = cell_in;
		end
		for (i = 0; i < 3; i++) begin
			window[i][0] = window[i][1];
			window[i][1] = window[i][2];
		end
		window[0][2] = top;
		window[1][2] = mid;
		window[2][2] = cell_in;
		if (r >= 1 && c >= 1) begin
			v = 0;
			if (r - 1 >= 1 && c - 1 >= 1 && r - 1 < h - 1 && c - 1 < w - 1) begin
				sum = 0;
				for (i = 0; i < 3; i++)
					for (j = 0; j < 3; j++)
						sum += window[i][j];
				centre = window[1][1];
				if (sum % RULE_MODULUS == 0)
					v = 0;
				else if (sum < gsg_pkg::RULE_LOW)
					v = (centre + gsg_pkg::RULE_STEP > CELL_MAX) ?
					    CELL_MAX : centre + gsg_pkg::RULE_STEP;
				else if (sum > gsg_pkg::RULE_LOW && sum < gsg_pkg::RULE_HIGH)
					v = (centre > gsg_pkg::RULE_STEP) ? centre - gsg_pkg::RULE_STEP : 0;
				else
					v = 1;
			end
			word.next_value = 8'(v);
			word.frame_last = last_row && last_col;
			next_gen_words.push_back(word);
		end
		if (last_col) begin
			col_at = '0;
			row_at = last_row ? '0 : ROW_BITS'(r + 1);
		end else begin
			col_at = COL_CFG_BITS'(c + 1);
		end
	endtask

	task automatic write_reg(input gsg_pkg::cfg_reg_t idx, input logic [CFG_BITS-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			gsg_pkg::REG_GRID_WIDTH: width_reg = data[COL_CFG_BITS-1:0];
			gsg_pkg::REG_GRID_HEIGHT: height_reg = data;
		endcase
	endtask

	task automatic settle();
		while (cell_backlog.size() != 0 || next_gen_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input idle_mode_t mode);
		int tally, w, h, grids, scale, g;
		logic [CFG_BITS-1:0] data;
		tally = 0;
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 52;
				recv_idle_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_idle_pct = 52;
			end
			IDLE_BOTH: begin
				send_idle_pct = 38;
				recv_idle_pct = 38;
			end
		endcase
		while (tally < PHASE_ITEMS) begin
			case ($urandom_range(0, 7))
				0: w = $urandom_range(0, gsg_pkg::MIN_DIM - 1);
				1: w = $urandom_range(13, 24);
				default: w = $urandom_range(gsg_pkg::MIN_DIM, 12);
			endcase
			case ($urandom_range(0, 7))
				0: h = $urandom_range(0, gsg_pkg::MIN_DIM - 1);
				1: h = $urandom_range(11, 20);
				default: h = $urandom_range(gsg_pkg::MIN_DIM, 10);
			endcase
			data = CFG_BITS'($urandom_range(0, 7) << COL_CFG_BITS) | CFG_BITS'(w);
			write_reg(gsg_pkg::REG_GRID_WIDTH, data);
			write_reg(gsg_pkg::REG_GRID_HEIGHT, CFG_BITS'(h));
			grids = $urandom_range(1, 2);
			for (g = 0; g < grids; g++) begin
				scale = $urandom_range(2, 40);
				repeat (eff_width() * eff_height())
					cell_backlog.push_back(rand_cell(scale));
				tally += eff_width() * eff_height();
			end
			settle();
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Offer the oldest pending cell; hold it while the block is full.
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!offer_held) begin
			if (cell_backlog.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
				push <= 1'b1;
				cell_value <= cell_backlog[0];
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_request != 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(1, 100) > recv_idle_pct);
		end
	end

	always @(posedge clk) begin : monitor
		gen_word_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (next_gen_words.size() == 0) begin
					$error("unexpected word: next_value %0d, frame_last %0b",
						next_value, frame_last);
					mismatches++;
				end else begin
					want = next_gen_words.pop_front();
					if (next_value !== want.next_value) begin
						$error("next_value: expected %0d, got %0d", want.next_value, next_value);
						mismatches++;
					end
					if (frame_last !== want.frame_last) begin
						$error("frame_last: expected %0b, got %0b", want.frame_last, frame_last);
						mismatches++;
					end
				end
			end
			offer_held = push && full;
			if (push && !full) begin
				void'(cell_backlog.pop_front());
				advance_grid(cell_value);
			end
		end
	end

	initial begin : stimulus
		int k;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		cell_value = '0;
		cfg_write = 1'b0;
		cfg_index = gsg_pkg::REG_GRID_WIDTH;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 0;
		stall_left = 0;
		offer_held = 1'b0;
		mismatches = 0;
		cycles = 0;
		row_at = '0;
		col_at = '0;
		width_reg = COL_CFG_BITS'(gsg_pkg::RESET_DIM);
		height_reg = ROW_BITS'(gsg_pkg::RESET_DIM);
		for (k = 0; k < MAX_COLS; k++) begin
			prev_row[k] = '0;
			older_row[k] = '0;
		end
		for (k = 0; k < 9; k++)
			window[k / 3][k % 3] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// seven columns, three rows: sums straddle each rule boundary
		write_reg(gsg_pkg::REG_GRID_WIDTH, {3'b111, 13'd7});
		write_reg(gsg_pkg::REG_GRID_HEIGHT, 16'd0);
		foreach (DIRECTED_CELLS[k])
			cell_backlog.push_back(DIRECTED_CELLS[k]);
		settle();

		run_phase(IDLE_NONE);

		// widest row start, shrink to forty columns under a long receiver stall,
		// then shrink width and height mid-grid
		write_reg(gsg_pkg::REG_GRID_WIDTH, 16'hFFFF);
		write_reg(gsg_pkg::REG_GRID_HEIGHT, 16'hFFFF);
		repeat (100)
			cell_backlog.push_back(rand_cell(20));
		settle();
		write_reg(gsg_pkg::REG_GRID_WIDTH, {3'b111, 13'd40});
		stall_request = LONG_STALL;
		repeat (90)
			cell_backlog.push_back(rand_cell(20));
		settle();
		write_reg(gsg_pkg::REG_GRID_WIDTH, {3'b101, 13'd8});
		write_reg(gsg_pkg::REG_GRID_HEIGHT, 16'd5);
		repeat (17)
			cell_backlog.push_back(rand_cell(20));
		settle();

		run_phase(IDLE_SENDER);
		run_phase(IDLE_RECEIVER);
		run_phase(IDLE_BOTH);

		// row counter already past the new last row
		write_reg(gsg_pkg::REG_GRID_WIDTH, 16'd6);
		write_reg(gsg_pkg::REG_GRID_HEIGHT, 16'd40);
		repeat (122)
			cell_backlog.push_back(rand_cell(30));
		settle();
		write_reg(gsg_pkg::REG_GRID_HEIGHT, 16'd10);
		repeat (4)
			cell_backlog.push_back(rand_cell(30));
		settle();

		if (mismatches == 0 && next_gen_words.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
